// File: src/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 12;
    localparam int STORE_DEPTH  = (HEAP_BYTES + 3) / 4;
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int OFF_W        = $clog2(HEAP_BYTES + 1);
    localparam int WORD_W       = OFF_W - 2;
    localparam int FIELD_W      = 16;
    localparam int LIMIT_W      = 17;
    localparam int STATUS_W     = 2;
    localparam int REQ_W        = FIELD_W + 1;
    localparam int SUM_W        = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 2;
    localparam int ENTRY_W      = WORD_W + 1;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(65536);
    localparam logic [0:0]          REG_HEAP_LIMIT = 1'b0;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NULL = 2'd2;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_FREE_HEAD,
        S_FREE_NEXT
    } state_t;

    // One datapath action per cycle, chosen by the controller.
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_READ_FIRST,
        DP_READ_NEXT,
        DP_READ_BLOCK,
        DP_FREE_LOOK,
        DP_GRANT,
        DP_APPEND,
        DP_OUT_FULL,
        DP_OUT_NULL,
        DP_OUT_OK,
        DP_FREE_SOLO,
        DP_FREE_MERGE
    } dp_op_t;

    typedef struct packed {
        logic is_free;
        logic req_zero;
        logic addr_null;
        logic addr_outside;
        logic heap_empty;
        logic hit;
        logic walk_end;
        logic fits;
        logic merge_ok;
    } dp_status_t;

endpackage

// File: src/ffha_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_datapath
// Header store, heap end, walk pointer and result registers.
// ----------------------------------------------------------------------------
module ffha_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ffha_pkg::dp_op_t                   op,
    output ffha_pkg::dp_status_t               stat,
    input  logic                               cmd,
    input  logic [ffha_pkg::FIELD_W-1:0]       request_bytes,
    input  logic [ffha_pkg::FIELD_W-1:0]       release_addr,
    input  logic [ffha_pkg::LIMIT_W-1:0]       heap_limit,
    output logic                               done,
    output logic [ffha_pkg::FIELD_W-1:0]       payload_addr,
    output logic [ffha_pkg::STATUS_W-1:0]      status
);
    import ffha_pkg::*;

    localparam logic [SUM_W-1:0] HDR    = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0] HEAP_S = SUM_W'(HEAP_BYTES);

    // Each header entry holds the free flag and the payload size in words.
    logic [ENTRY_W-1:0] mem [STORE_DEPTH];

    op_code_t            cmd_reg;
    logic [REQ_W-1:0]    size_reg;
    logic [FIELD_W-1:0]  addr_reg;
    logic [OFF_W-1:0]    cur_reg;
    logic [OFF_W-1:0]    held_reg;
    logic [OFF_W-1:0]    heap_end_reg;
    logic [OFF_W-1:0]    heap_end_next;
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic                done_reg;
    logic                done_next;
    logic [FIELD_W-1:0]  payload_reg;
    logic [FIELD_W-1:0]  payload_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic                rd_free;
    logic [SUM_W-1:0]    rd_bytes;
    logic [SUM_W-1:0]    cur_s;
    logic [SUM_W-1:0]    held_s;
    logic [SUM_W-1:0]    end_s;
    logic [SUM_W-1:0]    size_s;
    logic [SUM_W-1:0]    req_round;
    logic [SUM_W-1:0]    walk_next;
    logic [SUM_W-1:0]    free_next;
    logic [SUM_W-1:0]    new_end;
    logic [SUM_W-1:0]    limit_eff;
    logic [SUM_W-1:0]    merged_raw;
    logic [SUM_W-1:0]    merged;
    logic [SUM_W-1:0]    block_off;
    logic                rd_en;
    logic [SUM_W-1:0]    rd_off;
    logic                wr_en;
    logic [SUM_W-1:0]    wr_off;
    logic [ENTRY_W-1:0]  wr_data;

    assign rd_free   = rd_data_reg[ENTRY_W-1];
    assign rd_bytes  = SUM_W'({rd_data_reg[WORD_W-1:0], 2'b00});
    assign cur_s     = SUM_W'(cur_reg);
    assign held_s    = SUM_W'(held_reg);
    assign end_s     = SUM_W'(heap_end_reg);
    assign size_s    = SUM_W'(size_reg);
    assign req_round = (SUM_W'(request_bytes) + SUM_W'(3)) & ~SUM_W'(3);
    assign walk_next = cur_s + HDR + rd_bytes;
    assign free_next = cur_s + HDR + held_s;
    assign new_end   = end_s + HDR + size_s;
    assign limit_eff = (SUM_W'(heap_limit) > HEAP_S) ? HEAP_S : SUM_W'(heap_limit);
    assign merged_raw = held_s + HDR + rd_bytes;
    assign merged    = (merged_raw > HEAP_S) ? HEAP_S : merged_raw;
    assign block_off = SUM_W'(addr_reg) - HDR;

    always_comb
    begin
        stat.is_free      = (cmd_reg == OP_FREE);
        stat.req_zero     = (size_reg == '0);
        stat.addr_null    = (addr_reg == '0);
        stat.addr_outside = (SUM_W'(addr_reg) < HDR) || (block_off >= end_s);
        stat.heap_empty   = (heap_end_reg == '0);
        stat.hit          = rd_free && (rd_bytes >= size_s);
        stat.walk_end     = (walk_next >= end_s);
        stat.fits         = (new_end <= limit_eff);
        stat.merge_ok     = (free_next < end_s) && rd_free;
    end

    // Read address selection: the next header offset comes straight from the
    // registered read data, so the walk reads one header per cycle.
    always_comb
    begin
        rd_en  = 1'b0;
        rd_off = '0;
        case (op)
            DP_READ_FIRST:
            begin
                rd_en  = 1'b1;
                rd_off = '0;
            end
            DP_READ_NEXT, DP_FREE_LOOK:
            begin
                rd_en  = 1'b1;
                rd_off = walk_next;
            end
            DP_READ_BLOCK:
            begin
                rd_en  = 1'b1;
                rd_off = block_off;
            end
            default:
            begin
                rd_en  = 1'b0;
                rd_off = '0;
            end
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_off  = cur_s;
        wr_data = {1'b0, rd_data_reg[WORD_W-1:0]};
        case (op)
            DP_GRANT:
            begin
                wr_en   = 1'b1;
                wr_off  = cur_s;
                wr_data = {1'b0, rd_data_reg[WORD_W-1:0]};
            end
            DP_APPEND:
            begin
                wr_en   = stat.fits;
                wr_off  = end_s;
                wr_data = {1'b0, size_s[WORD_W+1:2]};
            end
            DP_FREE_SOLO:
            begin
                wr_en   = 1'b1;
                wr_off  = cur_s;
                wr_data = {1'b1, held_s[WORD_W+1:2]};
            end
            DP_FREE_MERGE:
            begin
                wr_en   = 1'b1;
                wr_off  = cur_s;
                wr_data = {1'b1, merged[WORD_W+1:2]};
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_off  = cur_s;
                wr_data = {1'b0, rd_data_reg[WORD_W-1:0]};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_off[IDX_W+1:2]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_off[IDX_W+1:2]];
        end
    end

    always_comb
    begin
        done_next     = 1'b1;
        payload_next  = '0;
        status_next   = STATUS_OK;
        heap_end_next = heap_end_reg;
        case (op)
            DP_GRANT:
            begin
                payload_next = FIELD_W'(cur_s + HDR);
            end
            DP_APPEND:
            begin
                // Growth that would pass the limit reports out of space.
                if (stat.fits)
                begin
                    payload_next  = FIELD_W'(end_s + HDR);
                    heap_end_next = OFF_W'(new_end);
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            DP_OUT_FULL:   status_next = STATUS_FULL;
            DP_OUT_NULL:   status_next = STATUS_NULL;
            DP_OUT_OK:     status_next = STATUS_OK;
            DP_FREE_SOLO:  status_next = STATUS_OK;
            DP_FREE_MERGE: status_next = STATUS_OK;
            default:       done_next   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_end_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            heap_end_reg <= heap_end_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        status_reg  <= status_next;
        if (op == DP_LOAD)
        begin
            cmd_reg  <= op_code_t'(cmd);
            size_reg <= req_round[REQ_W-1:0];
            addr_reg <= release_addr;
        end
        // The neighbor lookup of a free keeps the block offset for the
        // write-back of the freed header.
        if (rd_en && (op != DP_FREE_LOOK))
        begin
            cur_reg <= rd_off[OFF_W-1:0];
        end
        if (op == DP_FREE_LOOK)
        begin
            held_reg <= rd_bytes[OFF_W-1:0];
        end
    end

    assign done         = done_reg;
    assign payload_addr = payload_reg;
    assign status       = status_reg;

endmodule

// File: src/ffha_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_controller
// Sequencer for allocate walks and free merges.
// ----------------------------------------------------------------------------
module ffha_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ffha_pkg::dp_status_t stat,
    output ffha_pkg::dp_op_t     op
);
    import ffha_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_free)
                begin
                    state_next = (stat.addr_null || stat.addr_outside) ? S_IDLE : S_FREE_HEAD;
                end
                else
                begin
                    state_next = (stat.req_zero || stat.heap_empty) ? S_IDLE : S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.hit || stat.walk_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FREE_HEAD: state_next = S_FREE_NEXT;
            S_FREE_NEXT: state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op   = DP_NONE;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                op = start ? DP_LOAD : DP_NONE;
            end
            S_DECODE:
            begin
                if (stat.is_free)
                begin
                    if (stat.addr_null)
                    begin
                        op = DP_OUT_NULL;
                    end
                    else if (stat.addr_outside)
                    begin
                        op = DP_OUT_OK;
                    end
                    else
                    begin
                        op = DP_READ_BLOCK;
                    end
                end
                else if (stat.req_zero)
                begin
                    op = DP_OUT_NULL;
                end
                else if (stat.heap_empty)
                begin
                    op = DP_APPEND;
                end
                else
                begin
                    op = DP_READ_FIRST;
                end
            end
            S_WALK:
            begin
                if (stat.hit)
                begin
                    op = DP_GRANT;
                end
                else if (stat.walk_end)
                begin
                    op = DP_APPEND;
                end
                else
                begin
                    op = DP_READ_NEXT;
                end
            end
            S_FREE_HEAD: op = DP_FREE_LOOK;
            S_FREE_NEXT: op = stat.merge_ok ? DP_FREE_MERGE : DP_FREE_SOLO;
            default:     op = DP_NONE;
        endcase
    end

endmodule

// File: src/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a byte-addressed heap with one header per block.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Transfer
//  --------  ----------------------------------------  ------------------------
//  request   start, busy, cmd, request_bytes,          beat when start && !busy
//            release_addr
//  result    done, payload_addr, status                beat when done (1 cycle)
//  config    psel, penable, pwrite, paddr, pwdata,     APB write, pready high
//            prdata, pready
//
// An allocate decodes the request and then walks the block headers; the
// first-fit walk reads one header per cycle from the header store, so the
// time grows with the number of blocks in front of the fit. A zero-size
// allocate and a free of a null or out-of-heap pointer finish at decode;
// any other free reads the block header, then the neighbor.
// The result beat is in the first cycle with busy low, and a new request
// may be taken in that same cycle. The receiver cannot stall the result.
// Reset empties the heap and restores the limit register; the header store
// needs no clearing pass because the walk only reads headers below heap end.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic [ffha_pkg::FIELD_W-1:0]       request_bytes,
    input  logic [ffha_pkg::FIELD_W-1:0]       release_addr,
    output logic                               done,
    output logic [ffha_pkg::FIELD_W-1:0]       payload_addr,
    output logic [ffha_pkg::STATUS_W-1:0]      status,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ffha_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ffha_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ffha_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import ffha_pkg::*;

    logic [LIMIT_W-1:0] heap_limit_reg;
    logic [LIMIT_W-1:0] heap_limit_next;
    logic               cfg_write;
    dp_op_t             op;
    dp_status_t         stat;

    // The register index is the word address; only the limit register exists,
    // and writes to other words are dropped.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        heap_limit_next = heap_limit_reg;
        if (cfg_write && (paddr[2] == REG_HEAP_LIMIT))
        begin
            heap_limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= LIMIT_RESET;
        end
        else
        begin
            heap_limit_reg <= heap_limit_next;
        end
    end

    assign prdata = (paddr[2] == REG_HEAP_LIMIT) ? APB_DATA_W'(heap_limit_reg) : '0;

    // The controller picks one datapath action per cycle from the status flags.
    ffha_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .op    (op)
    );

    ffha_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .stat          (stat),
        .cmd           (cmd),
        .request_bytes (request_bytes),
        .release_addr  (release_addr),
        .heap_limit    (heap_limit_reg),
        .done          (done),
        .payload_addr  (payload_addr),
        .status        (status)
    );

    // Every finished request produces exactly one result beat as busy drops.
    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result beat");

    // A result beat only follows a request that was running.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a running request");

    // Failed or null requests never hand out an address.
    a_no_addr_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (payload_addr == '0))
        else $error("address returned with a failing status");

    // An accepted request always makes the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start");

endmodule

// File: tb/first_fit_heap_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_test
// Self-checking bench for the first-fit heap allocator.
// ----------------------------------------------------------------------------
// Requests go in on the start/busy port and every request beat is scored
// against a behavioral heap kept inside the bench. The bench heap mirrors
// the block headers, the heap end and the limit register. Each result beat
// is compared field by field with the oldest pending prediction.
// A short directed pass covers null requests, out-of-heap pointers, growth
// up to the exact limit, reuse, merging and repeated frees. Random traffic
// then runs under several limit settings, the extremes among them.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_test;

    import ffha_pkg::*;

    localparam int          CLK_HALF_NS  = 5;
    localparam int          DRAIN_CYCLES = 16;
    localparam longint      TIMEOUT_NS   = 64'd500_000_000;
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = APB_ADDR_W'(4 * REG_HEAP_LIMIT);

    // One result beat as the block presents it.
    typedef struct packed {
        logic [FIELD_W-1:0]  payload;
        logic [STATUS_W-1:0] status;
    } heap_result_t;

    // Every input starts at a known value. The request port is idle and the
    // configuration port sits in its idle APB phase until the first transfer.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   cmd = 1'b0;
    logic [FIELD_W-1:0]     request_bytes = '0;
    logic [FIELD_W-1:0]     release_addr = '0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic                   busy;
    logic                   done;
    logic [FIELD_W-1:0]     payload_addr;
    logic [STATUS_W-1:0]    status;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Bench copy of the heap: header contents per 4-byte slot, heap end,
    // and the limit register as last written.
    int unsigned            hdr_size [STORE_DEPTH];
    bit                     hdr_free [STORE_DEPTH];
    int unsigned            heap_end_m = 0;
    logic [LIMIT_W-1:0]     limit_reg = LIMIT_RESET;

    // Payload offsets that ever carried a header. Freeing any of them is
    // well defined, even after the header was swallowed by a merge.
    int unsigned            issued_payloads [$];
    heap_result_t           expected_results [$];

    bit                     sender_gaps = 1'b1;
    int                     error_count = 0;
    int                     results_checked = 0;
    int                     alloc_count = 0;
    int                     free_count = 0;
    int                     full_count = 0;
    int                     null_count = 0;
    int                     limit_writes = 0;

    first_fit_heap_allocator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .request_bytes (request_bytes),
        .release_addr  (release_addr),
        .done          (done),
        .payload_addr  (payload_addr),
        .status        (status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result.
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Heap prediction. Applies one request to the bench heap and returns
    // the result beat the block must produce for it.
    // ------------------------------------------------------------------
    function automatic heap_result_t predict_heap_op(input op_code_t op,
                                                     input logic [FIELD_W-1:0] req,
                                                     input logic [FIELD_W-1:0] addr);
        heap_result_t r;
        int unsigned  size;
        int unsigned  cur;
        int unsigned  lim;
        int unsigned  new_end;
        int unsigned  off;
        int unsigned  nxt;
        bit           found;
        r.payload = '0;
        r.status  = STATUS_OK;
        if (op == OP_ALLOC)
        begin
            if (req == '0)
            begin
                r.status = STATUS_NULL;
            end
            else
            begin
                // Sizes are whole words; a 16-bit request can round to 64 KiB.
                size  = (int'(req) + 3) & ~32'h3;
                cur   = 0;
                found = 1'b0;
                while (!found && cur < heap_end_m)
                begin
                    if (hdr_free[cur >> 2] && hdr_size[cur >> 2] >= size)
                        found = 1'b1;
                    else
                        cur = cur + HEADER_BYTES + hdr_size[cur >> 2];
                end
                if (found)
                begin
                    // First fit is reused whole, never split.
                    hdr_free[cur >> 2] = 1'b0;
                    r.payload = FIELD_W'(cur + HEADER_BYTES);
                end
                else
                begin
                    lim = (limit_reg > HEAP_BYTES) ? HEAP_BYTES : limit_reg;
                    new_end = heap_end_m + HEADER_BYTES + size;
                    if (new_end > lim)
                    begin
                        r.status = STATUS_FULL;
                    end
                    else
                    begin
                        hdr_size[heap_end_m >> 2] = size;
                        hdr_free[heap_end_m >> 2] = 1'b0;
                        r.payload = FIELD_W'(heap_end_m + HEADER_BYTES);
                        issued_payloads.push_back(heap_end_m + HEADER_BYTES);
                        heap_end_m = new_end;
                    end
                end
            end
        end
        else
        begin
            if (addr == '0)
            begin
                r.status = STATUS_NULL;
            end
            else if (addr >= HEADER_BYTES && int'(addr) - HEADER_BYTES < heap_end_m)
            begin
                // Mark free and absorb the directly following block if free.
                off  = int'(addr) - HEADER_BYTES;
                size = hdr_size[off >> 2];
                nxt  = off + HEADER_BYTES + size;
                if (nxt < heap_end_m && hdr_free[nxt >> 2])
                begin
                    size = size + HEADER_BYTES + hdr_size[nxt >> 2];
                    if (size > HEAP_BYTES)
                        size = HEAP_BYTES;
                end
                hdr_size[off >> 2] = size;
                hdr_free[off >> 2] = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side. One beat per call; start stays high into the next call
    // unless a random gap or a drain lowers it.
    // ------------------------------------------------------------------
    task automatic send_request(input op_code_t op,
                                input logic [FIELD_W-1:0] req,
                                input logic [FIELD_W-1:0] addr);
        heap_result_t exp_r;
        if (sender_gaps && $urandom_range(99) < 8)
        begin
            // Idle cycles carry junk on the payload to show it is ignored.
            start         <= 1'b0;
            cmd           <= 1'($urandom);
            request_bytes <= FIELD_W'($urandom);
            release_addr  <= FIELD_W'($urandom);
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start         <= 1'b1;
        cmd           <= op;
        request_bytes <= req;
        release_addr  <= addr;
        // The beat lands at the first edge that sees busy low.
        do
            @(posedge clk);
        while (busy !== 1'b0);
        exp_r = predict_heap_op(op, req, addr);
        expected_results.push_back(exp_r);
        if (op == OP_ALLOC)
            alloc_count++;
        else
            free_count++;
        if (exp_r.status == STATUS_FULL)
            full_count++;
        if (exp_r.status == STATUS_NULL)
            null_count++;
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_drain();
        start <= 1'b0;
        while (expected_results.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration side. Writes only happen with the block drained.
    // ------------------------------------------------------------------
    task automatic apb_transfer(input bit is_write, input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= LIMIT_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Return to the idle APB phase before the next transfer may start.
        @(posedge clk);
    endtask

    task automatic check_limit_readback();
        logic [APB_DATA_W-1:0] rdata;
        apb_transfer(1'b0, '0, rdata);
        if (rdata !== APB_DATA_W'(limit_reg))
        begin
            $display("%0t: limit readback mismatch, expected %0d, actual %0d",
                     $time, limit_reg, rdata);
            error_count++;
        end
    endtask

    task automatic set_heap_limit(input logic [LIMIT_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        wait_drain();
        apb_transfer(1'b1, APB_DATA_W'(value), unused);
        limit_reg = value;
        limit_writes++;
        check_limit_readback();
    endtask

    // ------------------------------------------------------------------
    // Result side. The block cannot be stalled, so every done beat is
    // scored in the cycle it appears.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        heap_result_t exp_r;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing pending, payload %0d status %0d",
                         $time, payload_addr, status);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                results_checked++;
                if (payload_addr !== exp_r.payload)
                begin
                    $display("%0t: payload_addr mismatch, expected %0d, actual %0d",
                             $time, exp_r.payload, payload_addr);
                    error_count++;
                end
                if (status !== exp_r.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_r.status, status);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset value of the limit, then a one-header limit and the maximum.
    // The write of all ones puts the limit above the heap size.
    task automatic test_register_access();
        check_limit_readback();
        set_heap_limit(LIMIT_W'(HEADER_BYTES));
        set_heap_limit('1);
        set_heap_limit(LIMIT_RESET);
    endtask

    // Requests that change nothing: zero size, null pointer, pointers that
    // fall outside the heap, and a request too large for any heap.
    task automatic test_null_requests();
        send_request(OP_FREE, 16'h1234, 16'd0);
        send_request(OP_ALLOC, 16'd0, 16'hFFFF);
        send_request(OP_FREE, 16'd0, 16'd5);
        send_request(OP_FREE, 16'hFFFF, 16'd40000);
        send_request(OP_ALLOC, 16'hFFFF, 16'h0);
        wait_drain();
    endtask

    // Growth from an empty heap, then growth that exactly reaches the limit
    // followed by requests that must run out of space.
    task automatic test_growth_and_limit();
        send_request(OP_ALLOC, 16'd1, 16'h5555);
        send_request(OP_ALLOC, 16'd4, 16'hAAAA);
        send_request(OP_ALLOC, 16'd100, 16'd0);
        set_heap_limit(LIMIT_W'(heap_end_m + HEADER_BYTES + 20));
        send_request(OP_ALLOC, 16'd17, 16'd0);
        send_request(OP_ALLOC, 16'd200, 16'd0);
        send_request(OP_ALLOC, 16'hAAAA, 16'h5555);
        send_request(OP_ALLOC, 16'h5555, 16'hAAAA);
        set_heap_limit(LIMIT_W'(HEADER_BYTES));
        send_request(OP_ALLOC, 16'd8, 16'd0);
    endtask

    // With growth shut off, freed blocks must be found again by the walk.
    // Covers a merge with the following block, repeated frees, a pointer a
    // few bytes into a header slot, and freeing a header lost to a merge.
    task automatic test_reuse_and_merge();
        send_request(OP_FREE, 16'hFFFF, 16'd28);
        send_request(OP_FREE, 16'h0001, 16'd12);
        send_request(OP_ALLOC, 16'd20, 16'hFFFF);
        send_request(OP_FREE, 16'd0, 16'd12);
        send_request(OP_FREE, 16'd0, 16'd12);
        send_request(OP_FREE, 16'd0, 16'd13);
        send_request(OP_FREE, 16'd0, 16'd28);
        send_request(OP_ALLOC, 16'd4, 16'd0);
        send_request(OP_FREE, 16'd0, 16'd44);
        send_request(OP_FREE, 16'd0, 16'd12);
        wait_drain();
    endtask

    // One random request. Most are allocates of modest size and frees of
    // blocks handed out; the rest are zero sizes, null and stray pointers.
    task automatic send_random_request(input int big_pct);
        int unsigned        roll;
        int unsigned        pick;
        int unsigned        lo;
        logic [FIELD_W-1:0] req;
        logic [FIELD_W-1:0] addr;
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        req  = FIELD_W'($urandom);
        addr = FIELD_W'($urandom);
        if (roll < 52)
        begin
            if (pick < big_pct)
                req = FIELD_W'($urandom);
            else if (pick < 70)
                req = FIELD_W'($urandom_range(64, 1));
            else if (pick < 95)
                req = FIELD_W'($urandom_range(512, 65));
            else
                req = FIELD_W'($urandom_range(4096, 513));
            send_request(OP_ALLOC, req, addr);
        end
        else if (roll < 90 && issued_payloads.size() != 0)
        begin
            addr = FIELD_W'(issued_payloads[$urandom_range(issued_payloads.size() - 1)]);
            send_request(OP_FREE, req, addr);
        end
        else
        begin
            lo = heap_end_m + HEADER_BYTES;
            case (pick % 5)
                0: send_request(OP_ALLOC, 16'd0, addr);
                1: send_request(OP_FREE, req, 16'd0);
                2: send_request(OP_FREE, req, FIELD_W'($urandom_range(HEADER_BYTES - 1, 1)));
                3:
                begin
                    // Past the heap end the pointer is simply ignored.
                    if (lo <= 16'hFFFF)
                        addr = FIELD_W'($urandom_range(16'hFFFF, lo));
                    else
                        addr = FIELD_W'($urandom_range(HEADER_BYTES - 1, 1));
                    send_request(OP_FREE, req, addr);
                end
                default:
                begin
                    // A few bytes into a known block still selects its slot.
                    if (issued_payloads.size() != 0)
                        addr = FIELD_W'(issued_payloads[$urandom_range(
                                   issued_payloads.size() - 1)] + $urandom_range(3, 1));
                    else
                        addr = FIELD_W'($urandom_range(HEADER_BYTES - 1, 1));
                    send_request(OP_FREE, req, addr);
                end
            endcase
        end
    endtask

    task automatic test_random_traffic(input logic [LIMIT_W-1:0] limit, input int count,
                                       input bit gaps, input int big_pct);
        set_heap_limit(limit);
        sender_gaps = gaps;
        for (int i = 0; i < count; i++)
        begin
            send_random_request(big_pct);
            // Now and then let the pipe run dry in mid traffic.
            if ($urandom_range(199) == 0)
                wait_drain();
        end
        wait_drain();
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_null_requests();
        test_growth_and_limit();
        test_reuse_and_merge();

        test_random_traffic(LIMIT_W'(1024), 250, 1'b1, 0);
        test_random_traffic(LIMIT_W'(4096), 250, 1'b1, 1);
        test_random_traffic(LIMIT_W'(HEADER_BYTES), 100, 1'b1, 0);
        test_random_traffic('1, 250, 1'b1, 3);
        // Last stretch runs with no sender gaps at all.
        test_random_traffic(LIMIT_RESET, 300, 1'b0, 2);

        wait_drain();
        $display("Covered %0d requests (%0d allocates, %0d frees) under %0d limit writes.",
                 alloc_count + free_count, alloc_count, free_count, limit_writes);
        $display("Scored %0d results: %0d out of space, %0d null; heap end %0d bytes.",
                 results_checked, full_count, null_count, heap_end_m);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
src/ffha_pkg.sv
src/ffha_datapath.sv
src/ffha_controller.sv
src/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_test.sv
